@@ src/rpa_pkg.sv @@
`default_nettype none
package rpa_pkg;

  localparam int NUM_PAGES = 4096;
  localparam int REF_BITS  = 8;

  localparam int PAGE_W  = 12;
  localparam int PAGE_AW = $clog2(NUM_PAGES);
  localparam int CNT_W   = $clog2(NUM_PAGES + 1);
  localparam int REQ_W   = 3;
  localparam int STAT_W  = 3;
  localparam int RC_W    = 8;
  localparam int FREE_W  = 13;

  localparam logic [CNT_W-1:0]    NUM_PAGES_C = CNT_W'(NUM_PAGES);
  localparam logic [PAGE_AW-1:0]  LAST_PAGE   = PAGE_AW'(NUM_PAGES - 1);
  localparam logic [REF_BITS-1:0] REF_MAX     = {REF_BITS{1'b1}};

  localparam logic [REQ_W-1:0] REQ_INIT   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ALLOC  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FREE   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_INCREF = 3'd3;
  localparam logic [REQ_W-1:0] REQ_GETREF = 3'd4;

  localparam logic [STAT_W-1:0] STATUS_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STATUS_OOM       = 3'd1;
  localparam logic [STAT_W-1:0] STATUS_RANGE     = 3'd2;
  localparam logic [STAT_W-1:0] STATUS_UNDERFLOW = 3'd3;
  localparam logic [STAT_W-1:0] STATUS_OVERFLOW  = 3'd4;

  localparam int APB_AW = 3;
  localparam logic [APB_AW-1:0] ADDR_FIRST_PAGE = 3'd0;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [PAGE_W-1:0] page_index;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PAGE_W-1:0] granted_page;
    logic [RC_W-1:0]   ref_count;
    logic [FREE_W-1:0] free_count;
  } res_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_SWEEP = 4'b1000
  } state_t;

endpackage
`default_nettype wire

@@ src/rpa_ram.sv @@
`default_nettype none
module rpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/rpa_cfg.sv @@
`default_nettype none
module rpa_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rpa_pkg::APB_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output logic      [rpa_pkg::PAGE_W-1:0] first_page
);

  logic [rpa_pkg::PAGE_W-1:0] first_page_r;
  logic [rpa_pkg::PAGE_W-1:0] first_page_nxt;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready &&
                  (paddr == rpa_pkg::ADDR_FIRST_PAGE);

  always_comb begin
    first_page_nxt = first_page_r;
    if (wr_en) begin
      first_page_nxt = pwdata[rpa_pkg::PAGE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_page_r <= '0;
    end else begin
      first_page_r <= first_page_nxt;
    end
  end

  assign prdata     = (paddr == rpa_pkg::ADDR_FIRST_PAGE) ?
                      {{(32-rpa_pkg::PAGE_W){1'b0}}, first_page_r} : 32'd0;
  assign first_page = first_page_r;

endmodule
`default_nettype wire

@@ src/rpa_core.sv @@
`default_nettype none
module rpa_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [rpa_pkg::PAGE_W-1:0] first_page,
  input  wire logic                       start,
  output logic                            busy,
  input  wire rpa_pkg::req_t              in_req,
  output logic                            out_valid,
  output rpa_pkg::res_t                   out_res
);

  rpa_pkg::state_t state_r, state_nxt;
  rpa_pkg::req_t   req_r, req_nxt;
  rpa_pkg::res_t   out_res_r, out_res_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic [rpa_pkg::CNT_W-1:0]   stack_depth_r, stack_depth_nxt;
  logic [rpa_pkg::CNT_W-1:0]   fresh_wm_r, fresh_wm_nxt;
  logic [rpa_pkg::CNT_W-1:0]   fresh_floor_r, fresh_floor_nxt;
  logic [rpa_pkg::PAGE_AW-1:0] sweep_idx_r, sweep_idx_nxt;

  logic                         cnt_we;
  logic [rpa_pkg::PAGE_AW-1:0]  cnt_waddr;
  logic [rpa_pkg::REF_BITS-1:0] cnt_wdata;
  logic [rpa_pkg::PAGE_AW-1:0]  cnt_raddr;
  logic [rpa_pkg::REF_BITS-1:0] cnt_rdata;

  logic                         stk_we;
  logic [rpa_pkg::PAGE_AW-1:0]  stk_waddr;
  logic [rpa_pkg::PAGE_W-1:0]   stk_wdata;
  logic [rpa_pkg::PAGE_AW-1:0]  stk_raddr;
  logic [rpa_pkg::PAGE_W-1:0]   stk_rdata;

  logic                         pg_high;
  logic                         pg_low;
  logic [rpa_pkg::REF_BITS-1:0] cnt_dec;
  logic [rpa_pkg::REF_BITS-1:0] cnt_inc;
  logic [rpa_pkg::PAGE_W-1:0]   fresh_page;
  logic [rpa_pkg::CNT_W-1:0]    first_page_ext;

  rpa_ram #(
    .WIDTH (rpa_pkg::REF_BITS),
    .DEPTH (rpa_pkg::NUM_PAGES)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  rpa_ram #(
    .WIDTH (rpa_pkg::PAGE_W),
    .DEPTH (rpa_pkg::NUM_PAGES)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign first_page_ext = {1'b0, first_page};
  assign pg_high    = ({1'b0, req_r.page_index} >= rpa_pkg::NUM_PAGES_C);
  assign pg_low     = (req_r.page_index < first_page);
  assign cnt_dec    = cnt_rdata - 1'b1;
  assign cnt_inc    = cnt_rdata + 1'b1;
  assign fresh_page = rpa_pkg::PAGE_W'(fresh_wm_r - 1'b1);

  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    out_res_nxt     = out_res_r;
    out_valid_nxt   = 1'b0;
    stack_depth_nxt = stack_depth_r;
    fresh_wm_nxt    = fresh_wm_r;
    fresh_floor_nxt = fresh_floor_r;
    sweep_idx_nxt   = sweep_idx_r;

    cnt_we    = 1'b0;
    cnt_waddr = sweep_idx_r;
    cnt_wdata = '0;
    cnt_raddr = rpa_pkg::PAGE_AW'(in_req.page_index);
    stk_we    = 1'b0;
    stk_waddr = rpa_pkg::PAGE_AW'(stack_depth_r);
    stk_wdata = req_r.page_index;
    stk_raddr = rpa_pkg::PAGE_AW'(stack_depth_r - 1'b1);

    case (state_r)
      rpa_pkg::ST_CLEAR: begin
        cnt_we        = 1'b1;
        sweep_idx_nxt = sweep_idx_r + 1'b1;
        if (sweep_idx_r == rpa_pkg::LAST_PAGE) begin
          state_nxt = rpa_pkg::ST_IDLE;
        end
      end
      rpa_pkg::ST_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          state_nxt = rpa_pkg::ST_EXEC;
          if (in_req.req_type == rpa_pkg::REQ_INIT) begin
            stack_depth_nxt = '0;
            if (first_page_ext < rpa_pkg::NUM_PAGES_C) begin
              fresh_floor_nxt = first_page_ext;
              fresh_wm_nxt    = rpa_pkg::NUM_PAGES_C;
              sweep_idx_nxt   = rpa_pkg::PAGE_AW'(first_page);
              state_nxt       = rpa_pkg::ST_SWEEP;
            end else begin
              fresh_floor_nxt = '0;
              fresh_wm_nxt    = '0;
            end
          end
        end
      end
      rpa_pkg::ST_SWEEP: begin
        cnt_we        = 1'b1;
        sweep_idx_nxt = sweep_idx_r + 1'b1;
        if (sweep_idx_r == rpa_pkg::LAST_PAGE) begin
          state_nxt                = rpa_pkg::ST_IDLE;
          out_valid_nxt            = 1'b1;
          out_res_nxt.status       = rpa_pkg::STATUS_OK;
          out_res_nxt.granted_page = '0;
          out_res_nxt.ref_count    = '0;
          out_res_nxt.free_count   = rpa_pkg::FREE_W'(stack_depth_r + fresh_wm_r -
                                                       fresh_floor_r);
        end
      end
      rpa_pkg::ST_EXEC: begin
        state_nxt                = rpa_pkg::ST_IDLE;
        out_valid_nxt            = 1'b1;
        out_res_nxt.status       = rpa_pkg::STATUS_OK;
        out_res_nxt.granted_page = '0;
        out_res_nxt.ref_count    = '0;
        cnt_waddr                = rpa_pkg::PAGE_AW'(req_r.page_index);
        case (req_r.req_type)
          rpa_pkg::REQ_ALLOC: begin
            if (stack_depth_r != '0) begin
              stack_depth_nxt          = stack_depth_r - 1'b1;
              out_res_nxt.granted_page = stk_rdata;
              out_res_nxt.ref_count    = rpa_pkg::RC_W'(1);
              cnt_we                   = 1'b1;
              cnt_waddr                = rpa_pkg::PAGE_AW'(stk_rdata);
              cnt_wdata                = rpa_pkg::REF_BITS'(1);
            end else if (fresh_wm_r > fresh_floor_r) begin
              fresh_wm_nxt             = fresh_wm_r - 1'b1;
              out_res_nxt.granted_page = fresh_page;
              out_res_nxt.ref_count    = rpa_pkg::RC_W'(1);
              cnt_we                   = 1'b1;
              cnt_waddr                = rpa_pkg::PAGE_AW'(fresh_page);
              cnt_wdata                = rpa_pkg::REF_BITS'(1);
            end else begin
              out_res_nxt.status = rpa_pkg::STATUS_OOM;
            end
          end
          rpa_pkg::REQ_FREE: begin
            if (pg_low || pg_high) begin
              out_res_nxt.status = rpa_pkg::STATUS_RANGE;
            end else if (cnt_rdata == '0) begin
              out_res_nxt.status = rpa_pkg::STATUS_UNDERFLOW;
            end else begin
              cnt_we                = 1'b1;
              cnt_wdata             = cnt_dec;
              out_res_nxt.ref_count = rpa_pkg::RC_W'(cnt_dec);
              if ((cnt_dec == '0) && (stack_depth_r < rpa_pkg::NUM_PAGES_C)) begin
                stk_we          = 1'b1;
                stack_depth_nxt = stack_depth_r + 1'b1;
              end
            end
          end
          rpa_pkg::REQ_INCREF: begin
            if (pg_high) begin
              out_res_nxt.status = rpa_pkg::STATUS_RANGE;
            end else if (cnt_rdata == rpa_pkg::REF_MAX) begin
              out_res_nxt.status    = rpa_pkg::STATUS_OVERFLOW;
              out_res_nxt.ref_count = rpa_pkg::RC_W'(cnt_rdata);
            end else begin
              cnt_we                = 1'b1;
              cnt_wdata             = cnt_inc;
              out_res_nxt.ref_count = rpa_pkg::RC_W'(cnt_inc);
            end
          end
          rpa_pkg::REQ_GETREF: begin
            if (pg_high) begin
              out_res_nxt.status = rpa_pkg::STATUS_RANGE;
            end else begin
              out_res_nxt.ref_count = rpa_pkg::RC_W'(cnt_rdata);
            end
          end
          default: begin
          end
        endcase
        out_res_nxt.free_count = rpa_pkg::FREE_W'(stack_depth_nxt + fresh_wm_nxt -
                                                   fresh_floor_nxt);
      end
      default: begin
        state_nxt = rpa_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= rpa_pkg::ST_CLEAR;
      out_valid_r   <= 1'b0;
      stack_depth_r <= '0;
      fresh_wm_r    <= '0;
      fresh_floor_r <= '0;
      sweep_idx_r   <= '0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      stack_depth_r <= stack_depth_nxt;
      fresh_wm_r    <= fresh_wm_nxt;
      fresh_floor_r <= fresh_floor_nxt;
      sweep_idx_r   <= sweep_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy      = (state_r != rpa_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transfer accepted but block not busy next cycle");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == rpa_pkg::ST_EXEC ||
                     $past(state_r) == rpa_pkg::ST_SWEEP))
    else $error("result strobe without a finishing request");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stack_depth_r <= rpa_pkg::NUM_PAGES_C)
    else $error("free stack depth beyond capacity");

  a_fresh_order: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_wm_r >= fresh_floor_r)
    else $error("fresh watermark below floor");

endmodule
`default_nettype wire

@@ src/refcounted_page_allocator.sv @@
// A request is taken only while idle, and none is taken again before its result is strobed.
// The count RAM is read as a request is taken and written back in the EXEC state.
// Init sweeps the count RAM from first_page to the top page, one entry a cycle,
// and strobes its result in the cycle after the sweep ends.
// Reset (synchronous): a clearing pass over all count RAM entries holds busy high;
// the APB port takes writes throughout. Results cannot be stalled by the receiver.
`default_nettype none
module refcounted_page_allocator (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rpa_pkg::APB_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  input  wire logic                       start,
  output logic                            busy,
  input  wire rpa_pkg::req_t              in_req,
  output logic                            out_valid,
  output rpa_pkg::res_t                   out_res
);

  logic [rpa_pkg::PAGE_W-1:0] first_page;

  rpa_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .first_page (first_page)
  );

  rpa_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .first_page (first_page),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_res    (out_res)
  );

endmodule
`default_nettype wire
